FILE: hdl/gosb_pkg.sv
package gosb_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int SEQ_DIGITS_DEFAULT = 3;

   localparam int WIN_W     = 6;
   localparam int SEQ_OUT_W = 10;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int SRC_W     = 2;

   localparam logic [WIN_W-1:0] WIN_RESET = 6'd4;

   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WIN_CLOSED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SEND    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ACK     = 3'd4;

   // where the response sequence number and byte come from
   localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
   localparam logic [SRC_W-1:0] SRC_PUSH = 2'd1;
   localparam logic [SRC_W-1:0] SRC_MEM  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SEQ_OUT_W-1:0] seq_number;
      logic [BYTE_W-1:0]    out_byte;
      logic                 window_open;
      logic                 buffer_empty;
      logic                 more_to_send;
   } rsp_type;

   typedef struct packed {
      logic                push_wr;
      logic                send_rd;
      logic                ack_rd;
      logic                load;
      logic [STATUS_W-1:0] status;
      logic [SRC_W-1:0]    src;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic nothing_unsent;
      logic window_closed;
      logic nothing_outstanding;
   } dp_stat_type;

endpackage

FILE: hdl/gosb_ctrl.sv
module gosb_ctrl
   import gosb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [KIND_W-1:0] kind,
   input  dp_stat_type stat,
   output cmd_type     cmd,
   output logic        busy,
   output logic        rsp_valid
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RESP = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign accept = start && !busy;

   always_comb begin
      cmd         = '0;
      cmd.load    = accept;
      cmd.status  = ST_OK;
      cmd.src     = SRC_NONE;
      case (kind)
         KIND_PUSH: begin
            if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.push_wr = accept;
               cmd.src     = SRC_PUSH;
            end
         end
         KIND_SEND: begin
            // nothing unsent takes priority over a closed window
            if (stat.nothing_unsent) begin
               cmd.status = ST_NO_SEND;
            end else if (stat.window_closed) begin
               cmd.status = ST_WIN_CLOSED;
            end else begin
               cmd.send_rd = accept;
               cmd.src     = SRC_MEM;
            end
         end
         KIND_ACK: begin
            if (stat.nothing_outstanding) begin
               cmd.status = ST_NO_ACK;
            end else begin
               cmd.ack_rd = accept;
               cmd.src    = SRC_MEM;
            end
         end
         default: begin
            cmd.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // busy also covers reset so that nothing is taken while it is asserted
   assign busy      = (state_ff == S_RESP) || reset;
   assign rsp_valid = (state_ff == S_RESP);

endmodule

FILE: hdl/gosb_dpath.sv
module gosb_dpath
   import gosb_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int SEQ_DIGITS = SEQ_DIGITS_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic              csr_wr,
   input  logic [WIN_W-1:0]  csr_wdata,
   input  cmd_type           cmd,
   output dp_stat_type       stat,
   output rsp_type           rsp_data
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int SEQ_MOD = 10 ** SEQ_DIGITS;
   localparam int SEQ_W   = $clog2(SEQ_MOD);
   localparam int CMP_W   = PTR_W + WIN_W;
   localparam int ENT_W   = SEQ_OUT_W + BYTE_W;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
   localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MOD - 1);

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // (snd - old) mod DEPTH, also for depths that are not a power of two
   function automatic logic [PTR_W-1:0] occupancy(input logic [PTR_W-1:0] snd,
                                                   input logic [PTR_W-1:0] old);
      logic [PTR_W:0] diff;
      diff = {1'b0, snd} - {1'b0, old};
      if (snd < old) diff = diff + DEPTH_X;
      return diff[PTR_W-1:0];
   endfunction

   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] oldest_ptr_ff, oldest_ptr_in;
   logic [PTR_W-1:0] send_ptr_ff, send_ptr_in;
   logic [SEQ_W-1:0] seq_cnt_ff, seq_cnt_in;
   logic [WIN_W-1:0] win_ff;

   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;
   logic [PTR_W-1:0] rd_addr;

   logic [SEQ_W+SEQ_OUT_W-1:0] seq_ext;
   logic [SEQ_OUT_W-1:0]       seq_low;

   logic [STATUS_W-1:0]  status_ff;
   logic [SRC_W-1:0]     src_ff;
   logic [SEQ_OUT_W-1:0] push_seq_ff;
   logic                 window_open_ff;
   logic                 buffer_empty_ff;
   logic                 more_to_send_ff;

   logic [CMP_W-1:0] occ_now, occ_next, win_ext;

   assign seq_ext = {{SEQ_OUT_W{1'b0}}, seq_cnt_ff};
   assign seq_low = seq_ext[SEQ_OUT_W-1:0];

   assign win_ext  = CMP_W'(win_ff);
   assign occ_now  = CMP_W'(occupancy(send_ptr_ff, oldest_ptr_ff));
   assign occ_next = CMP_W'(occupancy(send_ptr_in, oldest_ptr_in));

   always_comb begin
      stat.full                = (ring_next(write_ptr_ff) == oldest_ptr_ff);
      stat.nothing_unsent      = (send_ptr_ff == write_ptr_ff);
      stat.window_closed       = (occ_now >= win_ext);
      stat.nothing_outstanding = (oldest_ptr_ff == send_ptr_ff);
   end

   always_comb begin
      write_ptr_in  = cmd.push_wr ? ring_next(write_ptr_ff)  : write_ptr_ff;
      send_ptr_in   = cmd.send_rd ? ring_next(send_ptr_ff)   : send_ptr_ff;
      oldest_ptr_in = cmd.ack_rd  ? ring_next(oldest_ptr_ff) : oldest_ptr_ff;
      seq_cnt_in    = seq_cnt_ff;
      if (cmd.push_wr) begin
         seq_cnt_in = (seq_cnt_ff == SEQ_LAST) ? '0 : seq_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         oldest_ptr_ff <= '0;
         send_ptr_ff   <= '0;
         seq_cnt_ff    <= '0;
         win_ff        <= WIN_RESET;
      end else begin
         write_ptr_ff  <= write_ptr_in;
         oldest_ptr_ff <= oldest_ptr_in;
         send_ptr_ff   <= send_ptr_in;
         seq_cnt_ff    <= seq_cnt_in;
         if (csr_wr) win_ff <= csr_wdata;
      end
   end

   assign rd_addr = cmd.ack_rd ? oldest_ptr_ff : send_ptr_ff;

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[write_ptr_ff] <= {seq_low, req_data.data_byte};
      end
      if (cmd.send_rd || cmd.ack_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff       <= cmd.status;
         src_ff          <= cmd.src;
         push_seq_ff     <= seq_low;
         window_open_ff  <= (occ_next < win_ext);
         buffer_empty_ff <= (oldest_ptr_in == write_ptr_in);
         more_to_send_ff <= (send_ptr_in != write_ptr_in);
      end
   end

   always_comb begin
      rsp_data              = '0;
      rsp_data.status       = status_ff;
      rsp_data.window_open  = window_open_ff;
      rsp_data.buffer_empty = buffer_empty_ff;
      rsp_data.more_to_send = more_to_send_ff;
      case (src_ff)
         SRC_PUSH: begin
            rsp_data.seq_number = push_seq_ff;
         end
         SRC_MEM: begin
            rsp_data.seq_number = rd_data_ff[ENT_W-1:BYTE_W];
            rsp_data.out_byte   = rd_data_ff[BYTE_W-1:0];
         end
         default: begin
            rsp_data.seq_number = '0;
         end
      endcase
   end

endmodule

FILE: hdl/go_back_n_send_buffer.sv
// Sender window ring buffer. Each transaction (push, send or ack) is taken
// when start is high and busy is low; its single result appears in the next
// cycle with rsp_valid high for exactly one cycle, and busy is high during
// that cycle, so no new transaction is taken while a result is shown. The
// results and the entry store read are registered. busy is also high while
// reset is asserted. The receiver cannot stall: rsp_data is valid only
// while rsp_valid is high. The user writes window_size through the csr_
// channel (always ready) only while no transaction is pending; not enforced.
module go_back_n_send_buffer
   import gosb_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int SEQ_DIGITS = SEQ_DIGITS_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [WIN_W-1:0] csr_wdata
);

   cmd_type     cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   gosb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .kind      (req_data.kind),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   gosb_dpath #(
      .DEPTH      (DEPTH),
      .SEQ_DIGITS (SEQ_DIGITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/gosb_checker.sv
module gosb_checker
   import gosb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every accepted transaction gives its result in the following cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("no result after accepted transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // refused operations carry no sequence number or byte
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.seq_number == '0 && rsp_data.out_byte == '0)
      else $error("refused transaction returned data");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> !rsp_data.buffer_empty)
      else $error("full drop reported with empty buffer");

endmodule

bind go_back_n_send_buffer gosb_checker u_gosb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
